// File: rtl/core/mmr_pkg.sv
package mmr_pkg;

    localparam int STORE_DEPTH_DEF = 512;
    localparam int SAMPLE_W        = 8;
    localparam int IDX_W           = 9;
    localparam int PROD_W          = 2 * SAMPLE_W;
    localparam int CFG_IDX_W       = 2;

    localparam logic [SAMPLE_W-1:0] OUT_LOW_RST   = 8'd20;
    localparam logic [SAMPLE_W-1:0] OUT_HIGH_RST  = 8'd255;
    localparam logic [SAMPLE_W-1:0] RANGE_MIN_RST = 8'd255;
    localparam logic [SAMPLE_W-1:0] RANGE_MAX_RST = 8'd0;

    localparam logic [CFG_IDX_W-1:0] REG_OUT_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_HIGH = 2'd1;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DIV_START,
        ST_DIV,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic                start;
        logic [PROD_W-1:0]   dividend;
        logic [SAMPLE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// File: rtl/core/mmr_sample_store.sv
module mmr_sample_store
    import mmr_pkg::*;
#(
    parameter int DEPTH = STORE_DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic [SAMPLE_W-1:0] wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output logic [SAMPLE_W-1:0] rd_data
);

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/mmr_divider.sv
module mmr_divider
    import mmr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  div_req_t            req,
    output div_status_t         status,
    output logic [SAMPLE_W-1:0] quotient
);

    // Restoring division, one quotient bit a cycle; the caller guarantees
    // the quotient fits in SAMPLE_W bits, so the top half seeds the remainder.
    localparam int CNT_W = $clog2(SAMPLE_W + 1);

    logic [SAMPLE_W-1:0] rem_reg,  rem_next;
    logic [SAMPLE_W-1:0] quo_reg,  quo_next;
    logic [SAMPLE_W-1:0] dvs_reg,  dvs_next;
    logic [CNT_W-1:0]    cnt_reg,  cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [SAMPLE_W:0]   shifted;
    logic [SAMPLE_W:0]   trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[SAMPLE_W-1]};
        trial     = shifted - {1'b0, dvs_reg};
        if (req.start && !busy_reg)
        begin
            rem_next  = req.dividend[PROD_W-1:SAMPLE_W];
            quo_next  = req.dividend[SAMPLE_W-1:0];
            dvs_next  = req.divisor;
            cnt_next  = CNT_W'(SAMPLE_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // take the next dividend bit in and try the subtraction
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = trial[SAMPLE_W-1:0];
                quo_next = {quo_reg[SAMPLE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[SAMPLE_W-1:0];
                quo_next = {quo_reg[SAMPLE_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

// File: rtl/core/min_max_range_rescaler.sv
// Light sample recorder with min/max tracking and linear rescaling on read.
// Input channel (in_valid/in_ready): operation selects record or read.
//   A record stores sample at the next free entry (start_new restarts the
//   recording at entry zero) and updates the running minimum and maximum.
//   It completes in the accepting cycle and gives no output item.
//   A read returns one item on the output channel (out_valid/out_ready):
//   level = (entry - min) * (high - low) / (max - min) + low, truncated.
//   An index past the recorded entries returns the low level with
//   unrecorded set; a flat recording or high below low returns the low level.
// Path of a read: the store read, one 8x8 multiply and a restoring divider,
//   then the hold state and the output register. An unrecorded index skips
//   straight to the hold state, a degenerate range skips there from the fetch.
// Throughput: a record every cycle while no read is in progress; one read at a
//   time, in_ready low while it is being worked on, so no item is taken meanwhile.
// Output stall: the result sits in an output register; a finished read waits
//   in the hold state until that register frees, records still go through
//   while the output register is full.
// Reset: recording empty, min 255, max 0, low level 20, high level 255.
//   Store contents are not cleared; entries beyond the count never reach a result.
// Config port (cfg_valid/cfg_ready, always ready): index 0 low, 1 high.
module min_max_range_rescaler
    import mmr_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 operation,
    input  logic                 start_new,
    input  logic [SAMPLE_W-1:0]  sample,
    input  logic [IDX_W-1:0]     read_index,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [SAMPLE_W-1:0]  level,
    output logic                 unrecorded,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SAMPLE_W-1:0]  cfg_data
);

    localparam int AW   = $clog2(STORE_DEPTH);
    localparam int CW   = $clog2(STORE_DEPTH + 1);
    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;
    localparam int XW   = (AW > IDX_W) ? AW : IDX_W;

    state_t state_reg, state_next;

    logic [CW-1:0]       count_reg,    count_next;
    logic [SAMPLE_W-1:0] min_reg,      min_next;
    logic [SAMPLE_W-1:0] max_reg,      max_next;
    logic [SAMPLE_W-1:0] low_reg,      low_next;
    logic [SAMPLE_W-1:0] high_reg,     high_next;
    logic [PROD_W-1:0]   prod_reg,     prod_next;
    logic [SAMPLE_W-1:0] span_reg,     span_next;
    logic [SAMPLE_W-1:0] res_lvl_reg,  res_lvl_next;
    logic                res_unr_reg,  res_unr_next;
    logic                oval_reg,     oval_next;
    logic [SAMPLE_W-1:0] olvl_reg,     olvl_next;
    logic                ounr_reg,     ounr_next;

    logic                in_acc;
    logic                out_free;
    logic [CW-1:0]       base_count;
    logic [SAMPLE_W-1:0] base_min;
    logic [SAMPLE_W-1:0] base_max;
    logic [XW-1:0]       idx_ext;
    logic                idx_beyond;
    logic [SAMPLE_W-1:0] rd_data;
    logic [SAMPLE_W-1:0] clamped;
    logic [SAMPLE_W:0]   level_sum;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;

    div_req_t            div_req;
    div_status_t         div_status;
    logic [SAMPLE_W-1:0] quotient;

    mmr_sample_store #(
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (sample),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mmr_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .status   (div_status),
        .quotient (quotient)
    );

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_acc     = in_valid && in_ready;
    assign out_free   = !oval_reg || out_ready;
    assign cfg_ready  = 1'b1;

    // start_new restarts the recording before this sample goes in
    assign base_count = start_new ? '0 : count_reg;
    assign base_min   = start_new ? RANGE_MIN_RST : min_reg;
    assign base_max   = start_new ? RANGE_MAX_RST : max_reg;

    assign idx_ext    = XW'(read_index);
    assign idx_beyond = CMPW'(read_index) >= CMPW'(count_reg);

    assign wr_en      = in_acc && (operation == OP_RECORD)
                        && (base_count < CW'(STORE_DEPTH));
    assign wr_addr    = base_count[AW-1:0];
    assign rd_en      = in_acc && (operation == OP_READ);
    assign rd_addr    = idx_ext[AW-1:0];

    assign clamped    = (rd_data < min_reg) ? min_reg :
                        (rd_data > max_reg) ? max_reg : rd_data;
    assign level_sum  = {1'b0, quotient} + {1'b0, low_reg};

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        prod_next    = prod_reg;
        span_next    = span_reg;
        res_lvl_next = res_lvl_reg;
        res_unr_next = res_unr_reg;
        oval_next    = oval_reg && !out_ready;
        olvl_next    = olvl_reg;
        ounr_next    = ounr_reg;
        div_req      = '{start: 1'b0, dividend: prod_reg, divisor: span_reg};

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_OUT_LOW:  low_next  = cfg_data;
                REG_OUT_HIGH: high_next = cfg_data;
                default:      ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (operation == OP_RECORD)
                    begin
                        // drop the sample once the store is full
                        if (wr_en)
                        begin
                            count_next = base_count + CW'(1);
                            min_next   = (sample < base_min) ? sample : base_min;
                            max_next   = (sample > base_max) ? sample : base_max;
                        end
                    end
                    else if (idx_beyond)
                    begin
                        res_lvl_next = low_reg;
                        res_unr_next = 1'b1;
                        state_next   = ST_HOLD;
                    end
                    else
                    begin
                        res_unr_next = 1'b0;
                        state_next   = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                if (max_reg <= min_reg || high_reg < low_reg)
                begin
                    res_lvl_next = low_reg;
                    state_next   = ST_HOLD;
                end
                else
                begin
                    prod_next  = PROD_W'(clamped - min_reg) * PROD_W'(high_reg - low_reg);
                    span_next  = max_reg - min_reg;
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START:
            begin
                div_req.start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    res_lvl_next = level_sum[SAMPLE_W] ? '1 : level_sum[SAMPLE_W-1:0];
                    state_next   = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                // advance into the output register once it frees
                if (out_free)
                begin
                    oval_next  = 1'b1;
                    olvl_next  = res_lvl_reg;
                    ounr_next  = res_unr_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            min_reg   <= RANGE_MIN_RST;
            max_reg   <= RANGE_MAX_RST;
            low_reg   <= OUT_LOW_RST;
            high_reg  <= OUT_HIGH_RST;
            oval_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_next;
        span_reg    <= span_next;
        res_lvl_reg <= res_lvl_next;
        res_unr_reg <= res_unr_next;
        olvl_reg    <= olvl_next;
        ounr_reg    <= ounr_next;
    end

    assign out_valid  = oval_reg;
    assign level      = olvl_reg;
    assign unrecorded = ounr_reg;

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STORE_DEPTH))
        else $error("recorded count beyond store depth");

    a_range_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (min_reg <= max_reg))
        else $error("range minimum above maximum with entries recorded");

    a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_status.busy)
        else $error("divider started while busy");

    a_unrec_low: assert property (@(posedge clk) disable iff (!rst_n)
        (oval_reg && ounr_reg) |-> (olvl_reg == low_reg))
        else $error("unrecorded item without low level");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == ST_DIV))
        else $error("divider result outside divide state");
`endif

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

typedef struct packed {
    logic [mmr_pkg::SAMPLE_W-1:0] level;
    logic                         unrecorded;
} level_result_t;

class rescale_scoreboard;
    logic [mmr_pkg::SAMPLE_W-1:0] entries [mmr_pkg::STORE_DEPTH_DEF];
    int unsigned                  filled;
    logic [mmr_pkg::SAMPLE_W-1:0] span_min;
    logic [mmr_pkg::SAMPLE_W-1:0] span_max;
    logic [mmr_pkg::SAMPLE_W-1:0] floor_level;
    logic [mmr_pkg::SAMPLE_W-1:0] ceil_level;
    level_result_t                due_levels [$];
    int                           errors;

    function new();
        clear_recording();
        floor_level = mmr_pkg::OUT_LOW_RST;
        ceil_level  = mmr_pkg::OUT_HIGH_RST;
        errors      = 0;
    endfunction

    function void clear_recording();
        filled   = 0;
        span_min = mmr_pkg::RANGE_MIN_RST;
        span_max = mmr_pkg::RANGE_MAX_RST;
    endfunction

    function void write_reg(logic [mmr_pkg::CFG_IDX_W-1:0] idx,
                            logic [mmr_pkg::SAMPLE_W-1:0] data);
        if (idx == mmr_pkg::REG_OUT_LOW)
            floor_level = data;
        else if (idx == mmr_pkg::REG_OUT_HIGH)
            ceil_level = data;
    endfunction

    function logic [mmr_pkg::SAMPLE_W-1:0] rescaled_level(logic [mmr_pkg::SAMPLE_W-1:0] s);
        int unsigned lo;
        int unsigned hi;
        int unsigned mn;
        int unsigned mx;
        int unsigned v;
        int unsigned r;
        lo = floor_level;
        hi = ceil_level;
        mn = span_min;
        mx = span_max;
        v  = s;
        if (mx <= mn || hi < lo)
            return floor_level;
        if (v < mn)
            v = mn;
        if (v > mx)
            v = mx;
        r = ((v - mn) * (hi - lo)) / (mx - mn) + lo;
        if (r > 255)
            r = 255;
        return r[mmr_pkg::SAMPLE_W-1:0];
    endfunction

    function void note_item(logic op, logic start, logic [mmr_pkg::SAMPLE_W-1:0] smp,
                            logic [mmr_pkg::IDX_W-1:0] idx);
        level_result_t res;
        if (op == mmr_pkg::OP_RECORD) begin
            if (start)
                clear_recording();
            if (filled < mmr_pkg::STORE_DEPTH_DEF) begin
                entries[filled] = smp;
                filled++;
                if (smp < span_min)
                    span_min = smp;
                if (smp > span_max)
                    span_max = smp;
            end
        end
        else begin
            if (idx >= filled) begin
                res.level      = floor_level;
                res.unrecorded = 1'b1;
            end
            else begin
                res.level      = rescaled_level(entries[idx]);
                res.unrecorded = 1'b0;
            end
            due_levels.push_back(res);
        end
    endfunction

    function void check_level(logic [mmr_pkg::SAMPLE_W-1:0] got_level, logic got_unrec);
        level_result_t exp;
        if (due_levels.size() == 0) begin
            $error("unexpected item: level %0d, unrecorded %0d", got_level, got_unrec);
            errors++;
            return;
        end
        exp = due_levels.pop_front();
        if (got_level !== exp.level) begin
            $error("level mismatch: expected %0d, actual %0d", exp.level, got_level);
            errors++;
        end
        if (got_unrec !== exp.unrecorded) begin
            $error("unrecorded mismatch: expected %0d, actual %0d", exp.unrecorded, got_unrec);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import mmr_pkg::*;

    // Register indexes past the end of the list; writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // Cycles to let pass after the last result before touching the registers
    localparam int SETTLE_CYCLES = 24;
    localparam int N_PHASES      = 8;
    localparam int PHASE_ITEMS   = 110;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 operation = OP_RECORD;
    logic                 start_new = 1'b0;
    logic [SAMPLE_W-1:0]  sample = '0;
    logic [IDX_W-1:0]     read_index = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [SAMPLE_W-1:0]  level;
    logic                 unrecorded;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_OUT_LOW;
    logic [SAMPLE_W-1:0]  cfg_data = '0;

    rescale_scoreboard board;

    // Idling knobs, in percent of cycles
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // How the samples of the current recording session are shaped
    int                  sample_mode = 0;
    logic [SAMPLE_W-1:0] base_sample = '0;

    min_max_range_rescaler dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .start_new  (start_new),
        .sample     (sample),
        .read_index (read_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .level      (level),
        .unrecorded (unrecorded),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop, far beyond the slowest legal run
    initial
    begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: decide out_ready at each falling edge, stalling at the phase's rate
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            out_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Take each result item at the rising edge and check it against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_level(level, unrecorded);
    end

    // Offer one item; entered and left at a falling edge. Valid stays high
    // until the item is taken, and the payload does not move meanwhile.
    task automatic push_item(logic op, logic start, logic [SAMPLE_W-1:0] smp,
                             logic [IDX_W-1:0] idx);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        operation  = op;
        start_new  = start;
        sample     = smp;
        read_index = idx;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_item(op, start, smp, idx);
        @(negedge clk);
    endtask

    // Hold the input channel until every predicted result has been taken
    task automatic wait_drained();
        in_valid = 1'b0;
        while (board.due_levels.size() != 0)
            @(negedge clk);
    endtask

    // Drain, then let the block settle so no read is still in flight
    task automatic wait_idle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One register write; valid is dropped again before the task returns
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] v;
        case (sample_mode)
            0:       v = SAMPLE_W'($urandom_range(255));
            1:       v = base_sample;
            2:       v = base_sample + SAMPLE_W'($urandom_range(7));
            default:
            begin
                case ($urandom_range(2))
                    0:       v = '0;
                    1:       v = '1;
                    default: v = base_sample;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic void begin_session();
        sample_mode = $urandom_range(3);
        base_sample = SAMPLE_W'($urandom_range(255));
    endfunction

    // Mostly well-formed traffic: sessions opened by start_new, records, and
    // reads aimed at recorded entries; the rest is noise and boundary reads.
    task automatic run_phase(int n_items);
        int                  roll;
        logic [IDX_W-1:0]    idx;
        for (int i = 0; i < n_items; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 6 || (board.filled == 0 && roll < 50))
            begin
                begin_session();
                push_item(OP_RECORD, 1'b1, pick_sample(), IDX_W'($urandom_range(511)));
            end
            else if (roll < 50)
                push_item(OP_RECORD, 1'b0, pick_sample(), IDX_W'($urandom_range(511)));
            else if (roll < 86)
            begin
                if (board.filled > 0)
                    idx = IDX_W'($urandom_range(board.filled - 1));
                else
                    idx = IDX_W'($urandom_range(511));
                push_item(OP_READ, 1'($urandom_range(1)), SAMPLE_W'($urandom_range(255)), idx);
            end
            else if (roll < 90)
            begin
                // Just past the last recorded entry
                idx = IDX_W'((board.filled < STORE_DEPTH_DEF) ? board.filled
                                                              : $urandom_range(511));
                push_item(OP_READ, 1'($urandom_range(1)), SAMPLE_W'($urandom_range(255)), idx);
            end
            else
                push_item(1'($urandom_range(1)), 1'($urandom_range(1)),
                          SAMPLE_W'($urandom_range(255)), IDX_W'($urandom_range(511)));
            if ($urandom_range(99) < 2)
                wait_drained();
        end
    endtask

    // Fill the store to capacity, push past it, then read across the whole depth
    task automatic fill_store();
        begin_session();
        sample_mode = 0;
        push_item(OP_RECORD, 1'b1, pick_sample(), IDX_W'($urandom_range(511)));
        for (int i = 1; i < STORE_DEPTH_DEF + 8; i++)
            push_item(OP_RECORD, 1'b0, pick_sample(), IDX_W'($urandom_range(511)));
        push_item(OP_READ, 1'b0, SAMPLE_W'($urandom_range(255)), '1);
        push_item(OP_READ, 1'b0, SAMPLE_W'($urandom_range(255)), '0);
        for (int i = 0; i < 30; i++)
            push_item(OP_READ, 1'($urandom_range(1)), SAMPLE_W'($urandom_range(255)),
                      IDX_W'($urandom_range(511)));
        // A fresh recording shrinks the count again; the top entry turns unrecorded
        push_item(OP_RECORD, 1'b1, 8'd42, '0);
        push_item(OP_READ, 1'b0, '0, '1);
    endtask

    logic [SAMPLE_W-1:0] low_set  [N_PHASES] = '{8'd0, 8'd0, 8'd255, 8'd255,
                                                  8'd100, 8'd1, 8'd0, 8'd0};
    logic [SAMPLE_W-1:0] high_set [N_PHASES] = '{8'd255, 8'd0, 8'd255, 8'd0,
                                                  8'd50, 8'd254, 8'd0, 8'd0};

    initial
    begin
        board = new();

        // Single reset at the start; release on a falling edge
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Writes to unlisted indexes must leave the reset levels in place
        write_reg(REG_SPARE_A, SAMPLE_W'($urandom_range(255)));
        write_reg(REG_SPARE_B, SAMPLE_W'($urandom_range(255)));

        // Directed part at reset levels, no idling
        push_item(OP_READ, 1'b0, 8'h00, 9'd0);          // nothing recorded yet
        push_item(OP_RECORD, 1'b1, 8'h00, 9'h1FF);
        push_item(OP_READ, 1'b0, 8'hFF, 9'd0);          // flat recording
        push_item(OP_READ, 1'b0, 8'h00, 9'd1);          // unrecorded index
        push_item(OP_RECORD, 1'b0, 8'hFF, 9'h000);
        push_item(OP_RECORD, 1'b0, 8'h80, 9'h155);
        push_item(OP_READ, 1'b0, 8'h00, 9'd0);
        push_item(OP_READ, 1'b0, 8'h00, 9'd1);
        push_item(OP_READ, 1'b0, 8'h00, 9'd2);
        push_item(OP_READ, 1'b0, 8'h00, 9'h1FF);        // top index, unrecorded
        push_item(OP_READ, 1'b1, 8'h55, 9'd2);          // start_new ignored on a read
        push_item(OP_READ, 1'b0, 8'hAA, 9'd3);
        push_item(OP_RECORD, 1'b1, 8'hAA, 9'h0AA);
        push_item(OP_RECORD, 1'b0, 8'h55, 9'h155);
        push_item(OP_READ, 1'b0, 8'hFF, 9'd0);
        push_item(OP_READ, 1'b0, 8'h00, 9'd1);
        push_item(OP_READ, 1'b0, 8'h00, 9'd2);
        push_item(OP_RECORD, 1'b1, 8'd77, 9'd0);
        push_item(OP_RECORD, 1'b0, 8'd77, 9'd0);
        push_item(OP_READ, 1'b0, 8'd0, 9'd1);           // flat again
        push_item(OP_RECORD, 1'b0, 8'd78, 9'd0);
        push_item(OP_READ, 1'b0, 8'd0, 9'd2);
        push_item(OP_READ, 1'b0, 8'd0, 9'd0);

        // Random phases: each with its own levels and idling pattern
        for (int p = 0; p < N_PHASES; p++)
        begin
            wait_idle();
            if (p >= 6)
            begin
                low_set[p]  = SAMPLE_W'($urandom_range(255));
                high_set[p] = SAMPLE_W'($urandom_range(255));
            end
            write_reg(REG_OUT_LOW, low_set[p]);
            write_reg(REG_OUT_HIGH, high_set[p]);
            write_reg(($urandom_range(1) != 0) ? REG_SPARE_A : REG_SPARE_B,
                      SAMPLE_W'($urandom_range(255)));
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 49;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 49;
                end
                default:
                begin
                    send_idle_pct  = 18;
                    recv_stall_pct = 18;
                end
            endcase
            run_phase(PHASE_ITEMS);
        end

        // Capacity run at a mid range, both sides idling lightly
        wait_idle();
        write_reg(REG_OUT_LOW, 8'd10);
        write_reg(REG_OUT_HIGH, 8'd200);
        send_idle_pct  = 18;
        recv_stall_pct = 18;
        fill_store();

        // Wind down: every prediction met, then a settling tail
        wait_idle();
        if (board.errors == 0 && board.due_levels.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
